// ===== rtl/core/lcdn_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdn_pkg
// shared types, codes and the power-up table of the 4-bit lcd interface
// ----------------------------------------------------------------------------
package lcdn_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int QDEPTH          = 2;
   localparam int INIT_STEPS      = 9;
   localparam int CSR_ADDR_WIDTH  = 4;

   // request kinds
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_NIBBLE = 3'd1;
   localparam logic [2:0] CMD_BYTE   = 3'd2;
   localparam logic [2:0] CMD_CHAR   = 3'd3;
   localparam logic [2:0] CMD_CURSOR = 3'd4;
   localparam logic [2:0] CMD_INIT   = 3'd5;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_ENABLE_PULSE = 2'd0;
   localparam logic [1:0] REG_CHAR_DELAY   = 2'd1;
   localparam logic [1:0] REG_POWER_WAIT   = 2'd2;

   localparam logic [7:0]  RST_ENABLE_PULSE = 8'd1;
   localparam logic [15:0] RST_CHAR_DELAY   = 16'd46;
   localparam logic [15:0] RST_POWER_WAIT   = 16'd50000;

   localparam logic [7:0] CURSOR_BASE = 8'h80;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_POWER    = 6'b000010,
      PH_HI_FIRST = 6'b000100,
      PH_GAP      = 6'b001000,
      PH_HI_LAST  = 6'b010000,
      PH_POST     = 6'b100000
   } phase_type;

   typedef struct packed {
      logic        tick;
      logic        req;
      logic        init;
      logic        two;
      logic        rs;
      logic        char_dly;
      logic [7:0]  byte_v;
      logic [15:0] dly;
   } op_type;

   typedef struct packed {
      logic [7:0]  val;
      logic [15:0] dly;
      logic        two;
   } init_entry_type;

   function automatic init_entry_type init_entry(input logic [3:0] s);
      init_entry_type e;
      e = '0;
      unique case (s)
         4'd0:    e = '{val: 8'h03, dly: 16'd4100, two: 1'b0};
         4'd1:    e = '{val: 8'h03, dly: 16'd100,  two: 1'b0};
         4'd2:    e = '{val: 8'h03, dly: 16'd100,  two: 1'b0};
         4'd3:    e = '{val: 8'h02, dly: 16'd100,  two: 1'b0};
         4'd4:    e = '{val: 8'h28, dly: 16'd53,   two: 1'b1};
         4'd5:    e = '{val: 8'h08, dly: 16'd53,   two: 1'b1};
         4'd6:    e = '{val: 8'h01, dly: 16'd3000, two: 1'b1};
         4'd7:    e = '{val: 8'h06, dly: 16'd53,   two: 1'b1};
         4'd8:    e = '{val: 8'h0C, dly: 16'd53,   two: 1'b1};
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/core/char_lcd_nibble_interface_top.sv =====
// a request is written into the queue when accepted; its result is registered in the result register
// throughput: one request per cycle while the response side does not stall the result register
// a two-entry queue between decoder and engine and the result register decouple the sides
// reset: synchronous, active high; engine idle, pins low, registers at defaults
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_top
// 4-bit character lcd interface with register port, decoder and strobe engine
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_top
   import lcdn_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,  // value, delay_ticks, row, column
   input  logic [2:0]                req_tuser,  // command
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,  // bus_nibble, register_select,
                                                 // enable_pin, busy_res, rejected
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [7:0]  enable_pulse_ff;
   logic [15:0] char_delay_ff;
   logic [15:0] power_wait_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;
   logic        q_valid, q_ready;
   op_type      q_op;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_pulse_ff <= RST_ENABLE_PULSE;
         char_delay_ff   <= RST_CHAR_DELAY;
         power_wait_ff   <= RST_POWER_WAIT;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ENABLE_PULSE: enable_pulse_ff <= csr_pwdata[7:0];
            REG_CHAR_DELAY:   char_delay_ff   <= csr_pwdata[15:0];
            REG_POWER_WAIT:   power_wait_ff   <= csr_pwdata[15:0];
            default:          enable_pulse_ff <= enable_pulse_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ENABLE_PULSE: csr_prdata = {24'd0, enable_pulse_ff};
         REG_CHAR_DELAY:   csr_prdata = {16'd0, char_delay_ff};
         REG_POWER_WAIT:   csr_prdata = {16'd0, power_wait_ff};
         default:          csr_prdata = '0;
      endcase
   end

   lcdn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_op       (q_op)
   );

   lcdn_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_ready             (q_ready),
      .q_op                (q_op),
      .enable_pulse_ticks  (enable_pulse_ff),
      .char_delay_ticks    (char_delay_ff),
      .power_up_wait_ticks (power_wait_ff),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata)
   );

endmodule

// ===== rtl/core/lcdn_front.sv =====
// ----------------------------------------------------------------------------
// lcdn_front
// takes requests, decodes them into operations and queues them for the engine
// ----------------------------------------------------------------------------
module lcdn_front
   import lcdn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   output logic        q_valid,
   input  logic        q_ready,
   output op_type      q_op
);

   localparam int PTR_W = $clog2(QDEPTH);
   localparam int CNT_W = $clog2(QDEPTH + 1);

   op_type             q_mem_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   op_type             op_dec;
   logic               push, pop;

   logic [7:0]  value;
   logic [15:0] delay_ticks;
   logic        row;
   logic [5:0]  column;

   assign value       = req_tdata[7:0];
   assign delay_ticks = req_tdata[23:8];
   assign row         = req_tdata[24];
   assign column      = req_tdata[30:25];

   always_comb begin
      op_dec        = '0;
      op_dec.byte_v = value;
      op_dec.dly    = delay_ticks;
      unique case (req_tuser)
         CMD_TICK:   op_dec.tick = 1'b1;
         CMD_NIBBLE: op_dec.req  = 1'b1;
         CMD_BYTE: begin
            op_dec.req = 1'b1;
            op_dec.two = 1'b1;
         end
         CMD_CHAR: begin
            op_dec.req      = 1'b1;
            op_dec.two      = 1'b1;
            op_dec.rs       = 1'b1;
            op_dec.char_dly = 1'b1;
         end
         CMD_CURSOR: begin
            op_dec.req      = 1'b1;
            op_dec.two      = 1'b1;
            op_dec.char_dly = 1'b1;
            op_dec.byte_v   = CURSOR_BASE | {1'b0, row, 6'b0} | {2'b0, column};
         end
         CMD_INIT: begin
            op_dec.req  = 1'b1;
            op_dec.init = 1'b1;
         end
         default: op_dec.tick = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != CNT_W'(QDEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_op       = q_mem_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= op_dec;
      end
   end

endmodule

// ===== rtl/core/lcdn_back.sv =====
// ----------------------------------------------------------------------------
// lcdn_back
// strobe and delay engine, drives the lcd pin levels into the result register
// ----------------------------------------------------------------------------
module lcdn_back
   import lcdn_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  op_type      q_op,
   input  logic [7:0]  enable_pulse_ticks,
   input  logic [15:0] char_delay_ticks,
   input  logic [15:0] power_up_wait_ticks,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata
);

   localparam int CMAX = (2 ** COUNT_WIDTH) - 1;

   function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [15:0] v);
      logic [COUNT_WIDTH-1:0] r;
      if (COUNT_WIDTH >= 16) begin
         r = COUNT_WIDTH'(v);
      end else if (v > 16'(CMAX)) begin
         r = '1;
      end else begin
         r = COUNT_WIDTH'(v);
      end
      return r;
   endfunction

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in, cnt_dec, pulse;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic [15:0]            held_post_ff, held_post_in;
   logic [3:0]             init_step_ff, init_step_in;
   logic                   init_active_ff, init_active_in;
   logic [5:0]             pins_ff, pins_in;
   logic                   rej;
   logic                   out_valid_ff;
   logic [7:0]             out_data_ff;
   logic                   pop;

   logic                   do_start, do_end, do_finish, do_init_step;
   logic [7:0]             st_byte;
   logic                   st_two, st_rs;
   logic [15:0]            st_post;
   logic [COUNT_WIDTH-1:0] post_cnt, power_cnt;
   init_entry_type         ient;

   assign q_ready = !out_valid_ff || rsp_tready;
   assign pop     = q_valid && q_ready;

   assign pulse     = (enable_pulse_ticks == 8'd0) ? COUNT_WIDTH'(1)
                                                    : COUNT_WIDTH'(enable_pulse_ticks);
   assign cnt_dec   = (cnt_ff != '0) ? cnt_ff - COUNT_WIDTH'(1) : cnt_ff;
   assign post_cnt  = sat_count(held_post_ff);
   assign power_cnt = sat_count(power_up_wait_ticks);

   always_comb begin
      phase_in       = phase_ff;
      cnt_in         = cnt_ff;
      held_byte_in   = held_byte_ff;
      held_post_in   = held_post_ff;
      init_step_in   = init_step_ff;
      init_active_in = init_active_ff;
      pins_in        = pins_ff;
      rej            = 1'b0;
      do_start       = 1'b0;
      do_end         = 1'b0;
      do_finish      = 1'b0;
      do_init_step   = 1'b0;
      st_byte        = q_op.byte_v;
      st_two         = q_op.two;
      st_rs          = q_op.rs;
      st_post        = q_op.char_dly ? char_delay_ticks : q_op.dly;

      if (q_op.tick) begin
         unique case (phase_ff)
            PH_IDLE: phase_in = PH_IDLE;
            PH_POWER: begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  init_step_in = '0;
                  do_init_step = 1'b1;
               end
            end
            PH_HI_FIRST: begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  pins_in[5] = 1'b0;
                  phase_in   = PH_GAP;
               end
            end
            PH_GAP: begin
               pins_in  = {1'b1, pins_ff[4], held_byte_ff[3:0]};
               cnt_in   = pulse;
               phase_in = PH_HI_LAST;
            end
            PH_HI_LAST: begin
               cnt_in = cnt_dec;
               do_end = (cnt_dec == '0);
            end
            PH_POST: begin
               cnt_in    = cnt_dec;
               do_finish = (cnt_dec == '0);
            end
            default: phase_in = PH_IDLE;
         endcase
      end else if (q_op.req) begin
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else if (q_op.init) begin
            init_active_in = 1'b1;
            init_step_in   = '0;
            cnt_in         = power_cnt;
            phase_in       = PH_POWER;
            do_init_step   = (power_cnt == '0);
         end else begin
            do_start = 1'b1;
         end
      end

      if (do_end) begin
         pins_in[5] = 1'b0;
         cnt_in     = post_cnt;
         phase_in   = PH_POST;
         do_finish  = (post_cnt == '0);
      end

      if (do_finish) begin
         if (init_active_ff) begin
            init_step_in = init_step_ff + 4'd1;
            do_init_step = 1'b1;
         end else begin
            phase_in = PH_IDLE;
         end
      end

      ient = init_entry(init_step_in);
      if (do_init_step) begin
         if (init_step_in >= 4'(INIT_STEPS)) begin
            init_active_in = 1'b0;
            phase_in       = PH_IDLE;
         end else begin
            do_start = 1'b1;
            st_byte  = ient.val;
            st_two   = ient.two;
            st_rs    = 1'b0;
            st_post  = ient.dly;
         end
      end

      if (do_start) begin
         held_byte_in = st_byte;
         held_post_in = st_post;
         pins_in      = {1'b1, st_rs, st_two ? st_byte[7:4] : st_byte[3:0]};
         cnt_in       = pulse;
         phase_in     = st_two ? PH_HI_FIRST : PH_HI_LAST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         cnt_ff         <= '0;
         held_byte_ff   <= '0;
         held_post_ff   <= '0;
         init_step_ff   <= '0;
         init_active_ff <= 1'b0;
         pins_ff        <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff       <= phase_in;
            cnt_ff         <= cnt_in;
            held_byte_ff   <= held_byte_in;
            held_post_ff   <= held_post_in;
            init_step_ff   <= init_step_in;
            init_active_ff <= init_active_in;
            pins_ff        <= pins_in;
         end
         out_valid_ff <= pop || (out_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= {rej, (phase_in != PH_IDLE), pins_in};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef ASSERT_OFF
   a_enable_means_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff[5] |-> out_data_ff[6])
      else $error("enable high while engine reports idle");

   a_reject_means_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff[7] |-> out_data_ff[6])
      else $error("request dropped while engine idle");

   a_init_not_idle: assert property (@(posedge clock) disable iff (reset)
      init_active_ff |-> (phase_ff != PH_IDLE))
      else $error("init sequence active with engine idle");

   a_gap_enable_low: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_GAP) |-> !pins_ff[5])
      else $error("enable high between nibbles");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the 4-bit character lcd interface one cycle-accurate request at a
// time. Ticks and lcd requests stream in with random gaps, responses are
// drained with random stalls, and every response is compared field by field
// against a local model of the strobe engine. Register settings change
// between phases while the interface is idle.
// ----------------------------------------------------------------------------
module testbench;
   import lcdn_pkg::*;

   localparam int         WATCHDOG_LIMIT = 4000;
   localparam logic [2:0] CMD_SPARE_LO   = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI   = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE, ST_POWER, ST_HI_FIRST, ST_GAP, ST_HI_LAST, ST_POST
   } lcd_state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  value;
      logic [15:0] delay_ticks;
      logic        row;
      logic [5:0]  column;
   } lcd_request_type;

   typedef struct packed {
      logic       rejected;
      logic       busy_res;
      logic       enable_pin;
      logic       register_select;
      logic [3:0] bus_nibble;
   } pin_result_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [31:0]               req_tdata   = '0;  // value, delay_ticks, row, column
   logic [2:0]                req_tuser   = CMD_TICK;  // command
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [7:0]                rsp_tdata;  // bus_nibble, register_select, enable_pin,
                                          // busy_res, rejected
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [31:0]               csr_pwdata  = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   char_lcd_nibble_interface_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial forever #6 clock = ~clock;

   // model of the strobe engine
   logic [7:0]    pulse_cfg      = RST_ENABLE_PULSE;
   logic [15:0]   char_delay_cfg = RST_CHAR_DELAY;
   logic [15:0]   power_wait_cfg = RST_POWER_WAIT;
   lcd_state_type lcd_state      = ST_IDLE;
   int unsigned   lcd_count      = 0;
   logic [7:0]    held_val       = '0;
   logic [15:0]   held_post      = '0;
   logic [3:0]    boot_step      = '0;
   logic          boot_on        = 1'b0;
   logic [5:0]    pins           = '0;  // enable, rs, data

   logic [7:0]  boot_val [0:8] = '{8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06,
                                   8'h0C};
   logic [15:0] boot_dly [0:8] = '{16'd4100, 16'd100, 16'd100, 16'd100, 16'd53, 16'd53,
                                   16'd3000, 16'd53, 16'd53};
   logic        boot_two [0:8] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

   lcd_request_type lcd_requests [$];
   pin_result_type  pin_forecast [$];
   int unsigned     items_queued   = 0;
   int unsigned     mismatch_count = 0;
   int unsigned     idle_cycles    = 0;
   int unsigned     req_gap        = 0;
   int unsigned     rsp_stall      = 0;
   logic            req_fire       = 1'b0;
   logic            req_idle_on    = 1'b1;
   logic            rsp_idle_on    = 1'b1;

   function automatic int unsigned strobe_ticks();
      return (pulse_cfg == 8'd0) ? 1 : pulse_cfg;
   endfunction

   function automatic void strobe_begin(input logic [7:0] b, input logic two, input logic rs,
                                        input logic [15:0] post);
      held_val  = b;
      held_post = post;
      pins      = {1'b1, rs, two ? b[7:4] : b[3:0]};
      lcd_count = strobe_ticks();
      lcd_state = two ? ST_HI_FIRST : ST_HI_LAST;
   endfunction

   function automatic void boot_next();
      if (boot_step >= INIT_STEPS) begin
         boot_on   = 1'b0;
         lcd_state = ST_IDLE;
      end else begin
         strobe_begin(boot_val[boot_step], boot_two[boot_step], 1'b0, boot_dly[boot_step]);
      end
   endfunction

   function automatic void transfer_done();
      if (boot_on) begin
         boot_step = boot_step + 4'd1;
         boot_next();
      end else begin
         lcd_state = ST_IDLE;
      end
   endfunction

   function automatic void count_down();
      if (lcd_count > 0) lcd_count = lcd_count - 1;
   endfunction

   function automatic void tick_advance();
      case (lcd_state)
         ST_POWER: begin
            count_down();
            if (lcd_count == 0) begin
               boot_step = '0;
               boot_next();
            end
         end
         ST_HI_FIRST: begin
            count_down();
            if (lcd_count == 0) begin
               pins[5]   = 1'b0;
               lcd_state = ST_GAP;
            end
         end
         ST_GAP: begin
            pins      = {1'b1, pins[4], held_val[3:0]};
            lcd_count = strobe_ticks();
            lcd_state = ST_HI_LAST;
         end
         ST_HI_LAST: begin
            count_down();
            if (lcd_count == 0) begin
               pins[5]   = 1'b0;
               lcd_count = held_post;
               lcd_state = ST_POST;
               if (lcd_count == 0) transfer_done();
            end
         end
         ST_POST: begin
            count_down();
            if (lcd_count == 0) transfer_done();
         end
         default: lcd_state = ST_IDLE;
      endcase
   endfunction

   function automatic pin_result_type predict_pins(input lcd_request_type r);
      pin_result_type p;
      logic           rej;
      rej = 1'b0;
      if (r.command == CMD_TICK) begin
         tick_advance();
      end else if (r.command <= CMD_INIT) begin
         if (lcd_state != ST_IDLE) begin
            rej = 1'b1;
         end else begin
            case (r.command)
               CMD_NIBBLE: strobe_begin(r.value, 1'b0, 1'b0, r.delay_ticks);
               CMD_BYTE:   strobe_begin(r.value, 1'b1, 1'b0, r.delay_ticks);
               CMD_CHAR:   strobe_begin(r.value, 1'b1, 1'b1, char_delay_cfg);
               CMD_CURSOR: strobe_begin(CURSOR_BASE | {1'b0, r.row, 6'b0} | {2'b0, r.column},
                                        1'b1, 1'b0, char_delay_cfg);
               default: begin
                  boot_on   = 1'b1;
                  boot_step = '0;
                  lcd_count = power_wait_cfg;
                  lcd_state = ST_POWER;
                  if (lcd_count == 0) boot_next();
               end
            endcase
         end
      end
      p.bus_nibble      = pins[3:0];
      p.register_select = pins[4];
      p.enable_pin      = pins[5];
      p.busy_res        = (lcd_state != ST_IDLE);
      p.rejected        = rej;
      return p;
   endfunction

   function automatic void check_field(input string name, input logic [3:0] want,
                                       input logic [3:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
         mismatch_count++;
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   task automatic send(input logic [2:0] cmd, input logic [7:0] value, input logic [15:0] dly,
                       input logic row, input logic [5:0] col);
      lcd_request_type r;
      r.command     = cmd;
      r.value       = value;
      r.delay_ticks = dly;
      r.row         = row;
      r.column      = col;
      lcd_requests.push_back(r);
      items_queued++;
   endtask

   task automatic send_ticks(input int unsigned n);
      repeat (n) send(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic drain();
      while (lcd_requests.size() != 0 || req_tvalid || pin_forecast.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // run ticks until the engine has gone idle
   task automatic settle();
      drain();
      while (lcd_state != ST_IDLE) begin
         send_ticks(lcd_count + 4);
         drain();
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      logic [31:0] got;
      logic [31:0] mask;
      mask = (idx == REG_ENABLE_PULSE) ? 32'h0000_00FF : 32'h0000_FFFF;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ENABLE_PULSE: pulse_cfg      = data[7:0];
         REG_CHAR_DELAY:   char_delay_cfg = data[15:0];
         default:          power_wait_cfg = data[15:0];
      endcase
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== (data & mask)) begin
         $display("%0t: register %0d readback: expected %h, actual %h", $time, idx,
                  data & mask, got);
         mismatch_count++;
      end
   endtask

   task automatic random_phase(input int unsigned n_items);
      int unsigned first, need, post, burst;
      logic [2:0]  cmd;
      logic [15:0] dly;
      first = items_queued;
      while (items_queued - first < n_items) begin
         if ($urandom_range(0, 99) < 8) begin
            // noise and broken sequences
            if ($urandom_range(0, 1))
               send($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI, $urandom, $urandom,
                    $urandom, $urandom);
            else
               send($urandom_range(CMD_NIBBLE, CMD_CURSOR), $urandom, $urandom_range(0, 15),
                    $urandom, $urandom);
         end else begin
            cmd = $urandom_range(CMD_NIBBLE, CMD_CURSOR);
            dly = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
            send(cmd, $urandom, dly, $urandom, $urandom);
            post  = (cmd == CMD_NIBBLE || cmd == CMD_BYTE) ? dly : char_delay_cfg;
            need  = (cmd == CMD_NIBBLE) ? strobe_ticks() + post : 2 * strobe_ticks() + 1 + post;
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(0, need)
                                                : need + $urandom_range(0, 3);
            send_ticks(burst);
         end
      end
      settle();
   endtask

   // request driver
   always @(negedge clock) begin : request_driver
      lcd_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         req_tvalid <= 1'b1;
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap    <= req_gap - 1;
      end else if (lcd_requests.size() != 0) begin
         nxt = lcd_requests.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {1'b0, nxt.column, nxt.row, nxt.delay_ticks, nxt.value};
         req_tuser  <= nxt.command;
         req_gap    <= req_idle_on ? pick_gap() : 0;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_idle_on) rsp_stall <= pick_gap();
      end
   end

   always @(posedge clock) begin : monitor
      lcd_request_type r;
      pin_result_type  seen;
      pin_result_type  want;
      if (reset) begin
         req_fire    <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            r.command     = req_tuser;
            r.value       = req_tdata[7:0];
            r.delay_ticks = req_tdata[23:8];
            r.row         = req_tdata[24];
            r.column      = req_tdata[30:25];
            pin_forecast.push_back(predict_pins(r));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (pin_forecast.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = pin_forecast.pop_front();
               check_field("bus_nibble", want.bus_nibble, seen.bus_nibble);
               check_field("register_select", want.register_select, seen.register_select);
               check_field("enable_pin", want.enable_pin, seen.enable_pin);
               check_field("busy_res", want.busy_res, seen.busy_res);
               check_field("rejected", want.rejected, seen.rejected);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: short timings, every request kind, rejects and unused codes
      csr_write(REG_ENABLE_PULSE, 32'd2);
      csr_write(REG_CHAR_DELAY, 32'd3);
      csr_write(REG_POWER_WAIT, 32'd5);
      send(CMD_NIBBLE, 8'hFF, 16'd0, 1'b0, 6'd0);
      send_ticks(3);
      send(CMD_BYTE, 8'h00, 16'd2, 1'b1, 6'h3F);
      send_ticks(8);
      send(CMD_BYTE, 8'hA5, 16'd1, 1'b0, 6'd0);
      send(CMD_CHAR, 8'h41, 16'd0, 1'b0, 6'd0);
      send_ticks(2);
      send(CMD_NIBBLE, 8'h07, 16'd0, 1'b0, 6'd0);
      send_ticks(6);
      send(CMD_CHAR, 8'hFF, 16'hFFFF, 1'b1, 6'h3F);
      send_ticks(9);
      send(CMD_CHAR, 8'h00, 16'd0, 1'b0, 6'd0);
      send_ticks(9);
      send(CMD_CURSOR, 8'h5C, 16'd0, 1'b1, 6'h3F);
      send_ticks(9);
      send(CMD_CURSOR, 8'h00, 16'd0, 1'b0, 6'd0);
      send_ticks(9);
      send(CMD_SPARE_LO, 8'hFF, 16'hFFFF, 1'b1, 6'h3F);
      send(CMD_SPARE_HI, 8'h00, 16'd0, 1'b0, 6'd0);
      send(CMD_NIBBLE, 8'h0A, 16'd4, 1'b0, 6'd0);
      send(CMD_SPARE_HI, 8'h12, 16'd3, 1'b0, 6'd1);
      send_ticks(8);
      send(CMD_INIT, 8'h00, 16'd0, 1'b0, 6'd0);
      send(CMD_BYTE, 8'h33, 16'd0, 1'b0, 6'd0);
      send_ticks(3);
      send(CMD_INIT, 8'h00, 16'd0, 1'b0, 6'd0);
      settle();

      // widest pulse, long post delays, init without power-up wait
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      csr_write(REG_ENABLE_PULSE, 32'd255);
      csr_write(REG_CHAR_DELAY, 32'd200);
      csr_write(REG_POWER_WAIT, 32'd0);
      send(CMD_INIT, 8'hFF, 16'hFFFF, 1'b1, 6'h3F);
      settle();
      send(CMD_BYTE, 8'hC3, 16'd300, 1'b0, 6'd0);
      settle();
      send(CMD_CHAR, 8'h7E, 16'd0, 1'b0, 6'd0);
      settle();

      // zero pulse register, char delay of 1, widest power-up wait register
      csr_write(REG_ENABLE_PULSE, 32'd0);
      csr_write(REG_CHAR_DELAY, 32'd1);
      csr_write(REG_POWER_WAIT, 32'd65535);
      send(CMD_CHAR, 8'h5A, 16'd0, 1'b0, 6'd0);
      send_ticks(4);
      send(CMD_NIBBLE, 8'h05, 16'd0, 1'b0, 6'd0);
      settle();

      // random traffic
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      csr_write(REG_ENABLE_PULSE, 32'd1);
      csr_write(REG_CHAR_DELAY, 32'd1);
      csr_write(REG_POWER_WAIT, 32'd0);
      random_phase(225);

      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      csr_write(REG_ENABLE_PULSE, 32'd3);
      csr_write(REG_CHAR_DELAY, 32'd9);
      csr_write(REG_POWER_WAIT, 32'd2);
      random_phase(225);

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (2) begin
         csr_write(REG_ENABLE_PULSE, $urandom_range(1, 4));
         csr_write(REG_CHAR_DELAY, $urandom_range(1, 12));
         csr_write(REG_POWER_WAIT, $urandom_range(0, 65535));
         random_phase(225);
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pin_forecast.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/lcdn_pkg.sv
rtl/core/lcdn_front.sv
rtl/core/lcdn_back.sv
rtl/core/char_lcd_nibble_interface_top.sv
dv/testbench.sv
